// ----- src/gst_pkg.sv -----
package gst_pkg;

  localparam int unsigned SampleBits = 12;
  localparam int unsigned PhaseBits  = 6;
  localparam int unsigned CountBits  = 8;
  localparam int unsigned CfgIdxBits = 2;

  localparam logic [SampleBits-1:0] Midscale = 12'd2047;
  localparam logic [CountBits-1:0]  CountMax = 8'd255;

  localparam logic [CfgIdxBits-1:0] CfgSliceDivide = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgHalfPeriod  = 2'd1;

  localparam logic [CountBits-1:0] SliceDivideRst = 8'd5;
  localparam logic [CountBits-1:0] HalfPeriodRst  = 8'd20;

  typedef enum logic {
    OpControl = 1'b0,
    OpSample  = 1'b1
  } op_e;

  typedef struct packed {
    logic                  tone_active;
    logic [SampleBits-1:0] dac_value;
  } result_t;

  function automatic logic [SampleBits-1:0] sine_word(input logic [PhaseBits-1:0] idx);
    logic [SampleBits-1:0] w;
    case (idx)
      6'd0:  w = 12'd2047; 6'd1:  w = 12'd2247; 6'd2:  w = 12'd2446; 6'd3:  w = 12'd2641;
      6'd4:  w = 12'd2830; 6'd5:  w = 12'd3012; 6'd6:  w = 12'd3184; 6'd7:  w = 12'd3346;
      6'd8:  w = 12'd3495; 6'd9:  w = 12'd3630; 6'd10: w = 12'd3749; 6'd11: w = 12'd3853;
      6'd12: w = 12'd3939; 6'd13: w = 12'd4006; 6'd14: w = 12'd4055; 6'd15: w = 12'd4085;
      6'd16: w = 12'd4095; 6'd17: w = 12'd4085; 6'd18: w = 12'd4055; 6'd19: w = 12'd4006;
      6'd20: w = 12'd3939; 6'd21: w = 12'd3853; 6'd22: w = 12'd3749; 6'd23: w = 12'd3630;
      6'd24: w = 12'd3495; 6'd25: w = 12'd3346; 6'd26: w = 12'd3184; 6'd27: w = 12'd3012;
      6'd28: w = 12'd2830; 6'd29: w = 12'd2641; 6'd30: w = 12'd2446; 6'd31: w = 12'd2247;
      6'd32: w = 12'd2047; 6'd33: w = 12'd1846; 6'd34: w = 12'd1647; 6'd35: w = 12'd1452;
      6'd36: w = 12'd1263; 6'd37: w = 12'd1081; 6'd38: w = 12'd909;  6'd39: w = 12'd747;
      6'd40: w = 12'd598;  6'd41: w = 12'd463;  6'd42: w = 12'd344;  6'd43: w = 12'd240;
      6'd44: w = 12'd154;  6'd45: w = 12'd87;   6'd46: w = 12'd38;   6'd47: w = 12'd9;
      6'd48: w = 12'd0;    6'd49: w = 12'd9;    6'd50: w = 12'd38;   6'd51: w = 12'd87;
      6'd52: w = 12'd154;  6'd53: w = 12'd240;  6'd54: w = 12'd344;  6'd55: w = 12'd463;
      6'd56: w = 12'd598;  6'd57: w = 12'd747;  6'd58: w = 12'd909;  6'd59: w = 12'd1081;
      6'd60: w = 12'd1263; 6'd61: w = 12'd1452; 6'd62: w = 12'd1647; 6'd63: w = 12'd1846;
      default: w = Midscale;
    endcase
    return w;
  endfunction

endpackage

// ----- src/gst_core.sv -----
module gst_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gst_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [gst_pkg::CountBits-1:0]   cfg_data_i,
  input  logic                            accept_i,
  input  logic                            operation_i,
  input  logic                            alarm_state_i,
  output gst_pkg::result_t                result_o
);
  import gst_pkg::*;

  logic [CountBits-1:0]  slice_divide_q, half_period_q;
  logic [CountBits-1:0]  slice_count_q, slice_count_d;
  logic [CountBits-1:0]  burst_count_q, burst_count_d;
  logic                  tone_q, tone_d;
  logic [PhaseBits-1:0]  phase_q, phase_d;
  logic [SampleBits-1:0] held_q, held_d;
  logic [CountBits-1:0]  slice_inc, burst_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_divide_q <= SliceDivideRst;
      half_period_q  <= HalfPeriodRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSliceDivide: slice_divide_q <= cfg_data_i;
        CfgHalfPeriod:  half_period_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // counters saturate at the top rather than wrap
  assign slice_inc = (slice_count_q == CountMax) ? CountMax : slice_count_q + 8'd1;
  assign burst_inc = (burst_count_q == CountMax) ? CountMax : burst_count_q + 8'd1;

  always_comb begin
    slice_count_d = slice_count_q;
    burst_count_d = burst_count_q;
    tone_d        = tone_q;
    phase_d       = phase_q;
    held_d        = held_q;
    case (op_e'(operation_i))
      OpSample: begin
        if (tone_q) begin
          held_d  = sine_word(phase_q);
          phase_d = phase_q + 6'd1;
        end
      end
      OpControl: begin
        slice_count_d = slice_inc;
        if (slice_inc >= slice_divide_q) begin
          slice_count_d = '0;
          if (!alarm_state_i) begin
            // preset one past the half period so the tone starts on the next slice
            burst_count_d = (half_period_q == CountMax) ? CountMax : half_period_q + 8'd1;
            tone_d        = 1'b0;
            held_d        = Midscale;
          end else begin
            burst_count_d = burst_inc;
            if (burst_inc >= half_period_q) begin
              burst_count_d = '0;
              if (tone_q) begin
                tone_d = 1'b0;
                held_d = Midscale;
              end else begin
                tone_d = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_count_q <= '0;
      burst_count_q <= '0;
      tone_q        <= 1'b0;
      phase_q       <= '0;
      held_q        <= Midscale;
    end else if (accept_i) begin
      slice_count_q <= slice_count_d;
      burst_count_q <= burst_count_d;
      tone_q        <= tone_d;
      phase_q       <= phase_d;
      held_q        <= held_d;
    end
  end

  assign result_o.dac_value   = held_d;
  assign result_o.tone_active = tone_d;

endmodule

// ----- src/gated_sine_tone_burst.sv -----
// Alarm tone-burst generator. Each input word is a tick: tuser 0 is a control tick
// (tdata bit 0 carries the alarm state), tuser 1 is a sample tick that steps a
// 64-entry sine table while the tone is on. Every tick returns one word: the held
// 12-bit DAC value and the tone-active flag. One tick is taken per clock while the skid
// register is empty; the result is registered in the output register, and a two-deep
// output stage keeps input acceptance going for one more tick while the output stalls.
// Configuration writes (index 0 slice divide, index 1 half period) are for idle use.
module gated_sine_tone_burst (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] alarm_state, [7:1] zero
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [11:0] dac_value, [12] tone_active, [15:13] zero
);
  import gst_pkg::*;

  logic    accept;
  result_t result;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic    out_free;

  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  gst_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .operation_i   (s_axis_tuser),
    .alarm_state_i (s_axis_tdata[0]),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q <= skid_valid_q || accept;
        if (skid_valid_q) begin
          skid_valid_q <= accept;
        end
      end else if (accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // skid word always leaves before a newer one reaches the output
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : result;
      if (accept) begin
        skid_q <= result;
      end
    end else if (accept) begin
      skid_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.tone_active, out_q.dac_value};

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held with empty output stage");

  a_idle_midscale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[12]) |-> (m_axis_tdata[11:0] == Midscale))
    else $error("tone off but DAC word not midscale");

  a_accept_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !out_valid_q) |=> m_axis_tvalid)
    else $error("accepted word did not reach the output");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import gst_pkg::*;

  typedef enum logic {
    RowTick,
    RowCfg
  } row_kind_e;

  // One directed step: either a tick (optionally with a typed-in result) or a
  // pair of register writes (slice divide, half period).
  typedef struct packed {
    row_kind_e             kind;
    op_e                   op;
    logic                  alarm;
    logic                  typed;
    logic [SampleBits-1:0] dac;
    logic                  tone;
    logic [CountBits-1:0]  slice_val;
    logic [CountBits-1:0]  half_val;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [7:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [0] alarm_state, [7:1] zero
  logic        s_axis_tuser;   // [0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [11:0] dac_value, [12] tone_active, [15:13] zero

  logic [SampleBits-1:0] sine_lut [64] = '{
    12'd2047, 12'd2247, 12'd2446, 12'd2641, 12'd2830, 12'd3012, 12'd3184, 12'd3346,
    12'd3495, 12'd3630, 12'd3749, 12'd3853, 12'd3939, 12'd4006, 12'd4055, 12'd4085,
    12'd4095, 12'd4085, 12'd4055, 12'd4006, 12'd3939, 12'd3853, 12'd3749, 12'd3630,
    12'd3495, 12'd3346, 12'd3184, 12'd3012, 12'd2830, 12'd2641, 12'd2446, 12'd2247,
    12'd2047, 12'd1846, 12'd1647, 12'd1452, 12'd1263, 12'd1081, 12'd909,  12'd747,
    12'd598,  12'd463,  12'd344,  12'd240,  12'd154,  12'd87,   12'd38,   12'd9,
    12'd0,    12'd9,    12'd38,   12'd87,   12'd154,  12'd240,  12'd344,  12'd463,
    12'd598,  12'd747,  12'd909,  12'd1081, 12'd1263, 12'd1452, 12'd1647, 12'd1846
  };

  // Predicted block state
  logic [CountBits-1:0]  pr_slice_div;
  logic [CountBits-1:0]  pr_half_period;
  logic [CountBits-1:0]  pr_slice_cnt;
  logic [CountBits-1:0]  pr_burst_cnt;
  logic                  pr_tone_on;
  logic [PhaseBits-1:0]  pr_phase;
  logic [SampleBits-1:0] pr_held;

  result_t   dac_words_due[$];
  stim_row_t dir_rows[$];
  int        err_count = 0;
  bit        gap_en = 1'b0;
  bit        stall_en = 1'b0;
  bit        hold_req = 1'b0;

  gated_sine_tone_burst dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic result_t predict_tick(op_e op, logic alarm);
    result_t r;
    if (op == OpSample) begin
      if (pr_tone_on) begin
        pr_held  = sine_lut[pr_phase];
        pr_phase = pr_phase + 6'd1;
      end
    end else begin
      if (pr_slice_cnt != CountMax) begin
        pr_slice_cnt = pr_slice_cnt + 8'd1;
      end
      if (pr_slice_cnt >= pr_slice_div) begin
        pr_slice_cnt = '0;
        if (!alarm) begin
          // preset one past the half period so the tone starts on the next slice
          pr_burst_cnt = (pr_half_period == CountMax) ? CountMax : pr_half_period + 8'd1;
          pr_tone_on   = 1'b0;
          pr_held      = Midscale;
        end else begin
          if (pr_burst_cnt != CountMax) begin
            pr_burst_cnt = pr_burst_cnt + 8'd1;
          end
          if (pr_burst_cnt >= pr_half_period) begin
            pr_burst_cnt = '0;
            if (pr_tone_on) begin
              pr_tone_on = 1'b0;
              pr_held    = Midscale;
            end else begin
              pr_tone_on = 1'b1;
            end
          end
        end
      end
    end
    r.dac_value   = pr_held;
    r.tone_active = pr_tone_on;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    err_count++;
  endtask

  task automatic send_tick(input op_e op, input logic alarm, input logic typed,
                           input result_t want);
    result_t due;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'b0, alarm};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    due = predict_tick(op, alarm);
    dac_words_due.push_back(typed ? want : due);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (dac_words_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [7:0] slice_val, input logic [7:0] half_val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgSliceDivide;
    cfg_data_i <= slice_val;
    @(posedge clk_i);
    cfg_idx_i  <= CfgHalfPeriod;
    cfg_data_i <= half_val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    pr_slice_div   = slice_val;
    pr_half_period = half_val;
    @(posedge clk_i);
  endtask

  // Output side: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        hold_req = 1'b0;
        repeat (80) @(posedge clk_i);
      end else if (stall_en && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[12:0];
      if (dac_words_due.size() == 0) begin
        report_mismatch("word with none due", got, 0);
      end else begin
        want = dac_words_due.pop_front();
        if (got.dac_value != want.dac_value) begin
          report_mismatch("dac_value", got.dac_value, want.dac_value);
        end
        if (got.tone_active != want.tone_active) begin
          report_mismatch("tone_active", got.tone_active, want.tone_active);
        end
      end
    end
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    stim_row_t row;
    result_t   want;
    op_e       op;
    logic      alarm;
    logic      alarm_level;
    int        run_left;
    int        rnd;
    logic [7:0] slice_val;
    logic [7:0] half_val;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgSliceDivide;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OpControl;

    pr_slice_div   = SliceDivideRst;
    pr_half_period = HalfPeriodRst;
    pr_slice_cnt   = '0;
    pr_burst_cnt   = '0;
    pr_tone_on     = 1'b0;
    pr_phase       = '0;
    pr_held        = Midscale;

    // After reset: idle midscale, sample ticks ignored with tone off
    dir_rows.push_back('{RowTick, OpSample,  1'b1, 1'b1, 12'd2047, 1'b0, 8'd0, 8'd0});
    dir_rows.push_back('{RowTick, OpControl, 1'b1, 1'b1, 12'd2047, 1'b0, 8'd0, 8'd0});
    // Shortest slice and half period; slice count left at the new limit
    dir_rows.push_back('{RowCfg,  OpControl, 1'b0, 1'b0, 12'd0,    1'b0, 8'd1, 8'd1});
    dir_rows.push_back('{RowTick, OpControl, 1'b0, 1'b1, 12'd2047, 1'b0, 8'd0, 8'd0});
    dir_rows.push_back('{RowTick, OpControl, 1'b1, 1'b1, 12'd2047, 1'b1, 8'd0, 8'd0});
    dir_rows.push_back('{RowTick, OpSample,  1'b0, 1'b1, 12'd2047, 1'b1, 8'd0, 8'd0});
    dir_rows.push_back('{RowTick, OpSample,  1'b1, 1'b0, 12'd0,    1'b0, 8'd0, 8'd0});
    // tone off: midscale at once, phase kept for the next burst
    dir_rows.push_back('{RowTick, OpControl, 1'b1, 1'b1, 12'd2047, 1'b0, 8'd0, 8'd0});
    dir_rows.push_back('{RowTick, OpSample,  1'b0, 1'b1, 12'd2047, 1'b0, 8'd0, 8'd0});
    dir_rows.push_back('{RowTick, OpControl, 1'b1, 1'b1, 12'd2047, 1'b1, 8'd0, 8'd0});
    dir_rows.push_back('{RowTick, OpSample,  1'b1, 1'b0, 12'd0,    1'b0, 8'd0, 8'd0});
    // zero registers: every control tick is a slice, every slice with the alarm on toggles
    dir_rows.push_back('{RowCfg,  OpControl, 1'b0, 1'b0, 12'd0,    1'b0, 8'd0, 8'd0});
    dir_rows.push_back('{RowTick, OpControl, 1'b1, 1'b1, 12'd2047, 1'b0, 8'd0, 8'd0});
    dir_rows.push_back('{RowTick, OpControl, 1'b1, 1'b1, 12'd2047, 1'b1, 8'd0, 8'd0});
    dir_rows.push_back('{RowTick, OpSample,  1'b0, 1'b0, 12'd0,    1'b0, 8'd0, 8'd0});
    dir_rows.push_back('{RowTick, OpControl, 1'b0, 1'b1, 12'd2047, 1'b0, 8'd0, 8'd0});
    // half period 255: preset and burst count saturate
    dir_rows.push_back('{RowCfg,  OpControl, 1'b0, 1'b0, 12'd0,    1'b0, 8'd1, 8'd255});
    dir_rows.push_back('{RowTick, OpControl, 1'b0, 1'b1, 12'd2047, 1'b0, 8'd0, 8'd0});
    dir_rows.push_back('{RowTick, OpControl, 1'b1, 1'b1, 12'd2047, 1'b1, 8'd0, 8'd0});
    dir_rows.push_back('{RowTick, OpSample,  1'b1, 1'b0, 12'd0,    1'b0, 8'd0, 8'd0});
    dir_rows.push_back('{RowCfg,  OpControl, 1'b0, 1'b0, 12'd0,    1'b0, 8'd255, 8'd254});
    dir_rows.push_back('{RowTick, OpControl, 1'b1, 1'b0, 12'd0,    1'b0, 8'd0, 8'd0});
    dir_rows.push_back('{RowTick, OpSample,  1'b0, 1'b0, 12'd0,    1'b0, 8'd0, 8'd0});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == RowCfg) begin
        wait_idle();
        set_regs(row.slice_val, row.half_val);
      end else begin
        want.dac_value   = row.dac;
        want.tone_active = row.tone;
        send_tick(row.op, row.alarm, row.typed, want);
      end
    end

    want        = '0;
    alarm_level = 1'b0;
    run_left    = 0;
    for (int phase = 0; phase < 12; phase++) begin
      wait_idle();
      gap_en   = (phase < 10) && (phase != 2);
      stall_en = (phase < 10);
      rnd = $urandom_range(0, 9);
      slice_val = (rnd == 0) ? 8'd0 : (rnd == 1) ? 8'd255 : 8'($urandom_range(1, 4));
      rnd = $urandom_range(0, 9);
      half_val = (rnd == 0) ? 8'd0 : (rnd == 1) ? 8'd255 : (rnd == 2) ? 8'd254 :
                 8'($urandom_range(1, 6));
      set_regs(slice_val, half_val);
      // block fills while the output is held off
      if (phase == 2) hold_req = 1'b1;
      for (int n = 0; n < 78; n++) begin
        if (gap_en && $urandom_range(0, 3) == 0) begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
        // alarm held in runs of control ticks, with the odd flipped word
        if (run_left == 0) begin
          alarm_level = ($urandom_range(0, 3) != 0);
          run_left    = $urandom_range(1, 30);
        end
        op = ($urandom_range(0, 9) < 6) ? OpSample : OpControl;
        if (op == OpSample) begin
          alarm = 1'($urandom_range(0, 1));
        end else begin
          alarm = ($urandom_range(0, 19) == 0) ? ~alarm_level : alarm_level;
          run_left--;
        end
        send_tick(op, alarm, 1'b0, want);
      end
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
